### design/cdpr_pkg.sv
package cdpr_pkg;

  // display geometry
  localparam int SCREEN_SIDE = 640;

  // time limits
  localparam logic [3:0] MAX_HOURS   = 4'd12;
  localparam logic [5:0] MAX_MIN_SEC = 6'd59;

  // reset time and palette
  localparam logic [3:0] RST_HOURS         = 4'd5;
  localparam logic [5:0] RST_MINUTES       = 6'd12;
  localparam logic [5:0] RST_SECONDS       = 6'd0;
  localparam logic [7:0] RST_HOURS_COLOR   = 8'd90;
  localparam logic [7:0] RST_MINUTES_COLOR = 8'd100;
  localparam logic [7:0] RST_SECONDS_COLOR = 8'd50;
  localparam logic [7:0] RST_COLON_COLOR   = 8'd28;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_SET   = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_t;

  // configuration register indices
  typedef enum logic [1:0] {
    REG_HOURS_COLOR   = 2'd0,
    REG_MINUTES_COLOR = 2'd1,
    REG_SECONDS_COLOR = 2'd2,
    REG_COLON_COLOR   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } clk_time_t;

  typedef struct packed {
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] colon;
  } palette_t;

  // tens digit of a value below 64, by multiply with 13/128
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = {4'b0, v} * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  // units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] t10;
    logic [5:0] u;
    t10 = {2'b0, tens_of(v)} * 6'd10;
    u   = v - t10;
    return u[3:0];
  endfunction

endpackage

### design/cdpr_clock.sv
module cdpr_clock (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  cdpr_pkg::mode_t       mode,
  input  cdpr_pkg::clk_time_t   set_time,
  output cdpr_pkg::clk_time_t   time_cur,
  output cdpr_pkg::clk_time_t   time_nxt
);

  cdpr_pkg::clk_time_t time_r;
  cdpr_pkg::clk_time_t time_upd;

  // tick with carries, clamped load, or hold for the other modes
  always_comb begin
    time_upd = time_r;
    case (mode)
      cdpr_pkg::MODE_TICK: begin
        if (time_r.seconds >= cdpr_pkg::MAX_MIN_SEC) begin
          time_upd.seconds = '0;
          if (time_r.minutes >= cdpr_pkg::MAX_MIN_SEC) begin
            time_upd.minutes = '0;
            if (time_r.hours >= cdpr_pkg::MAX_HOURS) begin
              time_upd.hours = '0;
            end else begin
              time_upd.hours = time_r.hours + 4'd1;
            end
          end else begin
            time_upd.minutes = time_r.minutes + 6'd1;
          end
        end else begin
          time_upd.seconds = time_r.seconds + 6'd1;
        end
      end
      cdpr_pkg::MODE_SET: begin
        time_upd.hours   = (set_time.hours > cdpr_pkg::MAX_HOURS) ?
                           cdpr_pkg::MAX_HOURS : set_time.hours;
        time_upd.minutes = (set_time.minutes > cdpr_pkg::MAX_MIN_SEC) ?
                           cdpr_pkg::MAX_MIN_SEC : set_time.minutes;
        time_upd.seconds = (set_time.seconds > cdpr_pkg::MAX_MIN_SEC) ?
                           cdpr_pkg::MAX_MIN_SEC : set_time.seconds;
      end
      default: begin
        time_upd = time_r;
      end
    endcase
  end

  // time state, moves when the staged transaction leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r.hours   <= cdpr_pkg::RST_HOURS;
      time_r.minutes <= cdpr_pkg::RST_MINUTES;
      time_r.seconds <= cdpr_pkg::RST_SECONDS;
    end else if (advance) begin
      time_r <= time_upd;
    end
  end

  assign time_cur = time_r;
  assign time_nxt = time_upd;

endmodule

### design/cdpr_glyph.sv
module cdpr_glyph (
  input  logic                 query,
  input  logic [9:0]           pixel_x,
  input  logic [9:0]           pixel_y,
  input  cdpr_pkg::clk_time_t  time_cur,
  input  cdpr_pkg::palette_t   palette,
  output logic                 written,
  output logic [7:0]           color
);

  localparam logic [10:0] SIDE    = 11'(cdpr_pkg::SCREEN_SIDE);
  localparam logic [5:0]  BOX_W   = 6'd54;
  localparam logic [9:0]  BOX_Y0  = 10'd160;
  localparam logic [9:0]  BOX_Y1  = 10'd320;
  localparam logic [3:0]  BOX_LO  = 4'd1;
  localparam logic [3:0]  BOX_HI  = 4'd8;

  // stroke test for one digit inside its box
  function automatic logic digit_on(input logic [3:0] d, input logic [5:0] dx,
                                    input logic [7:0] dy);
    logic top, bot, lft, rgt, mid, upper;
    top   = dy < 8'd20;
    bot   = dy > 8'd140;
    lft   = dx < 6'd20;
    rgt   = dx > 6'd34;
    mid   = (dy > 8'd80) && (dy < 8'd100);
    upper = dy <= 8'd80;
    case (d)
      4'd0: return top || lft || rgt || bot;
      4'd1: return (dx >= 6'd17) && (dx <= 6'd37);
      4'd2: return top || (rgt && dy < 8'd80) || (dy >= 8'd80 && dy < 8'd100)
                   || (lft && dy > 8'd80) || bot;
      4'd3: return top || (dy > 8'd70 && dy < 8'd90) || bot || rgt;
      4'd4: return (lft && upper) || mid || rgt;
      4'd5: return top || (lft && upper) || mid || (rgt && !upper) || bot;
      4'd6: return lft || top || mid || (rgt && !upper) || bot;
      4'd7: return top || rgt;
      4'd8: return top || mid || bot || lft || rgt;
      4'd9: return top || mid || bot || (lft && upper) || rgt;
      default: return 1'b0;
    endcase
  endfunction

  logic [3:0] box;
  logic [5:0] dx;
  logic [7:0] dy;
  logic [9:0] dy_full;
  logic       in_box;
  logic       is_colon;
  logic [3:0] digit;
  logic [7:0] field_color;
  logic       on;

  // box placement
  assign box     = pixel_x[9:6];
  assign dx      = pixel_x[5:0];
  assign dy_full = pixel_y - BOX_Y0;
  assign dy      = dy_full[7:0];
  assign in_box  = ({1'b0, pixel_x} < SIDE) && ({1'b0, pixel_y} < SIDE)
                   && (box >= BOX_LO) && (box <= BOX_HI)
                   && (dx != 6'd0) && (dx < BOX_W)
                   && (pixel_y > BOX_Y0) && (pixel_y < BOX_Y1);

  // digit and colour for each box
  always_comb begin
    digit       = 4'd0;
    field_color = palette.colon;
    is_colon    = 1'b0;
    case (box)
      4'd1: begin
        digit = cdpr_pkg::tens_of({2'b0, time_cur.hours});
        field_color = palette.hours;
      end
      4'd2: begin
        digit = cdpr_pkg::units_of({2'b0, time_cur.hours});
        field_color = palette.hours;
      end
      4'd4: begin
        digit = cdpr_pkg::tens_of(time_cur.minutes);
        field_color = palette.minutes;
      end
      4'd5: begin
        digit = cdpr_pkg::units_of(time_cur.minutes);
        field_color = palette.minutes;
      end
      4'd7: begin
        digit = cdpr_pkg::tens_of(time_cur.seconds);
        field_color = palette.seconds;
      end
      4'd8: begin
        digit = cdpr_pkg::units_of(time_cur.seconds);
        field_color = palette.seconds;
      end
      default: begin
        is_colon = 1'b1;
      end
    endcase
  end

  // colon dots or digit strokes
  assign on = is_colon ?
              (((dy > 8'd16) && (dy < 8'd56)) || ((dy > 8'd104) && (dy < 8'd144))) :
              digit_on(digit, dx, dy);

  assign written = query && in_box;
  assign color   = (written && on) ? field_color : 8'd0;

endmodule

### design/clock_digit_pixel_renderer_top.sv
// path: an accepted input transaction is held in the item register, and its result
//   is loaded into the result register when it leaves, which waits while out_tready is low
// throughput: one transaction per cycle unless out_tready stalls, set by the single pass
//   of time update and glyph lookup between the item register and the result register
// reset: synchronous, active low; clears both stages, reloads the colour
//   registers and sets the time to 05:12:00
module clock_digit_pixel_renderer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_x, pixel_y, set_hours, set_minutes, set_seconds
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_written, pixel_color, hours_now, minutes_now,
                                  // seconds_now
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  cdpr_pkg::palette_t  palette_r;
  logic                stg_valid_r;
  cdpr_pkg::mode_t     stg_mode_r;
  logic [9:0]          stg_x_r;
  logic [9:0]          stg_y_r;
  cdpr_pkg::clk_time_t stg_set_r;
  logic                out_valid_r;
  logic                out_written_r;
  logic [7:0]          out_color_r;
  cdpr_pkg::clk_time_t out_time_r;

  logic                advance;
  logic                in_take;
  cdpr_pkg::clk_time_t time_cur;
  cdpr_pkg::clk_time_t time_nxt;
  logic                glyph_written;
  logic [7:0]          glyph_color;

  // handshake between stages
  assign advance   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r.hours   <= cdpr_pkg::RST_HOURS_COLOR;
      palette_r.minutes <= cdpr_pkg::RST_MINUTES_COLOR;
      palette_r.seconds <= cdpr_pkg::RST_SECONDS_COLOR;
      palette_r.colon   <= cdpr_pkg::RST_COLON_COLOR;
    end else if (cfg_we) begin
      unique case (cdpr_pkg::reg_idx_t'(cfg_addr))
        cdpr_pkg::REG_HOURS_COLOR:   palette_r.hours   <= cfg_wdata;
        cdpr_pkg::REG_MINUTES_COLOR: palette_r.minutes <= cfg_wdata;
        cdpr_pkg::REG_SECONDS_COLOR: palette_r.seconds <= cfg_wdata;
        cdpr_pkg::REG_COLON_COLOR:   palette_r.colon   <= cfg_wdata;
        default:                     palette_r         <= palette_r;
      endcase
    end
  end

  // item register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  // item register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_mode_r        <= cdpr_pkg::mode_t'(in_tuser);
      stg_x_r           <= in_tdata[9:0];
      stg_y_r           <= in_tdata[19:10];
      stg_set_r.hours   <= in_tdata[23:20];
      stg_set_r.minutes <= in_tdata[29:24];
      stg_set_r.seconds <= in_tdata[35:30];
    end
  end

  cdpr_clock u_clock (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .mode     (stg_mode_r),
    .set_time (stg_set_r),
    .time_cur (time_cur),
    .time_nxt (time_nxt)
  );

  cdpr_glyph u_glyph (
    .query    (stg_mode_r == cdpr_pkg::MODE_QUERY),
    .pixel_x  (stg_x_r),
    .pixel_y  (stg_y_r),
    .time_cur (time_cur),
    .palette  (palette_r),
    .written  (glyph_written),
    .color    (glyph_color)
  );

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_written_r <= glyph_written;
      out_color_r   <= glyph_color;
      out_time_r    <= time_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_time_r.seconds, out_time_r.minutes, out_time_r.hours,
                       out_color_r, out_written_r};

`ifndef SYNTHESIS
  // time reported never leaves its limits
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_time_r.hours <= cdpr_pkg::MAX_HOURS &&
                     out_time_r.minutes <= cdpr_pkg::MAX_MIN_SEC &&
                     out_time_r.seconds <= cdpr_pkg::MAX_MIN_SEC))
    else $error("reported time out of range");

  // only a pixel query may write a pixel
  a_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_mode_r != cdpr_pkg::MODE_QUERY) |=>
      (!out_written_r && out_color_r == 8'd0))
    else $error("pixel written by a non-query transaction");

  // a colour is only given to a written pixel
  a_color_written: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_color_r != 8'd0) |-> out_written_r)
    else $error("colour without pixel write");

  // the clock state holds while no transaction leaves the item register
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(time_cur))
    else $error("time changed without a transaction");
`endif

endmodule

### tb/clock_render_checker.sv
module clock_render_checker
  import cdpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_x, pixel_y, set_hours, set_minutes, set_seconds
  input  logic [1:0]  in_tuser,   // mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // pixel_written, pixel_color, hours_now, minutes_now,
                                  // seconds_now
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  output int          mismatch_count,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // glyph geometry in pixels
  localparam int BOX_PITCH = 64;
  localparam int BOX_W     = 54;
  localparam int BOX_TOP   = 160;
  localparam int BOX_H     = 160;
  localparam int STROKE    = 20;
  localparam int HALF_H    = 80;
  localparam int ONE_LEFT  = 17;
  localparam int ONE_RIGHT = 37;
  localparam int DOT_NEAR  = 16;
  localparam int DOT_FAR   = 56;

  typedef struct {
    logic       written;
    logic [7:0] color;
    clk_time_t  now;
  } pixel_result_t;

  clk_time_t     time_now;
  palette_t      colors;
  pixel_result_t owed_q[$];
  int            fails = 0;
  int            owed  = 0;

  assign mismatch_count = fails;
  assign results_owed   = owed;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fails++;
  endtask

  // seven-segment style strokes of one decimal digit
  function automatic bit stroke_lit(input int digit, input int dx, input int dy);
    bit top, bot, lft, rgt, mid, upper;
    top   = dy < STROKE;
    bot   = dy > BOX_H - STROKE;
    lft   = dx < STROKE;
    rgt   = dx > BOX_W - STROKE;
    mid   = dy > HALF_H && dy < HALF_H + STROKE;
    upper = dy <= HALF_H;
    case (digit)
      0: return top || lft || rgt || bot;
      1: return dx >= ONE_LEFT && dx <= ONE_RIGHT;
      2: return top || (rgt && dy < HALF_H) || (dy >= HALF_H && dy < HALF_H + STROKE)
                || (lft && dy > HALF_H) || bot;
      3: return top || (dy > HALF_H - STROKE / 2 && dy < HALF_H + STROKE / 2) || bot || rgt;
      4: return (lft && upper) || mid || rgt;
      5: return top || (lft && upper) || mid || (rgt && !upper) || bot;
      6: return lft || top || mid || (rgt && !upper) || bot;
      7: return top || rgt;
      8: return top || mid || bot || lft || rgt;
      9: return top || mid || bot || (lft && upper) || rgt;
      default: return 1'b0;
    endcase
  endfunction

  // which box a pixel falls in, and the colour it takes there
  function automatic void shade_pixel(input int x, input int y,
                                      output logic written, output logic [7:0] color);
    int  box, dx, dy, digit;
    bit  lit;
    logic [7:0] ink;
    written = 1'b0;
    color   = 8'd0;
    if (x >= SCREEN_SIDE || y >= SCREEN_SIDE) return;
    box = x / BOX_PITCH;
    dx  = x % BOX_PITCH;
    if (box < 1 || box > 8 || dx == 0 || dx >= BOX_W) return;
    if (y <= BOX_TOP || y >= BOX_TOP + BOX_H) return;
    dy    = y - BOX_TOP;
    digit = 0;
    case (box)
      1: begin digit = int'(time_now.hours) / 10;   ink = colors.hours;   end
      2: begin digit = int'(time_now.hours) % 10;   ink = colors.hours;   end
      4: begin digit = int'(time_now.minutes) / 10; ink = colors.minutes; end
      5: begin digit = int'(time_now.minutes) % 10; ink = colors.minutes; end
      7: begin digit = int'(time_now.seconds) / 10; ink = colors.seconds; end
      8: begin digit = int'(time_now.seconds) % 10; ink = colors.seconds; end
      default: ink = colors.colon;
    endcase
    if (box == 3 || box == 6)
      lit = (dy > DOT_NEAR && dy < DOT_FAR) || (dy > BOX_H - DOT_FAR && dy < BOX_H - DOT_NEAR);
    else
      lit = stroke_lit(digit, dx, dy);
    written = 1'b1;
    color   = lit ? ink : 8'd0;
  endfunction

  // one second forward, carrying into minutes and hours
  function automatic void advance_second();
    if (time_now.seconds == MAX_MIN_SEC) begin
      time_now.seconds = '0;
      if (time_now.minutes == MAX_MIN_SEC) begin
        time_now.minutes = '0;
        time_now.hours   = (time_now.hours >= MAX_HOURS) ? 4'd0 : time_now.hours + 4'd1;
      end else begin
        time_now.minutes = time_now.minutes + 6'd1;
      end
    end else begin
      time_now.seconds = time_now.seconds + 6'd1;
    end
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    logic [3:0]    set_h;
    logic [5:0]    set_m, set_s;
    logic [5:0]    got_m, got_s;
    logic [3:0]    got_h;
    if (!rst_n) begin
      time_now = '{hours: RST_HOURS, minutes: RST_MINUTES, seconds: RST_SECONDS};
      colors   = '{hours: RST_HOURS_COLOR, minutes: RST_MINUTES_COLOR,
                   seconds: RST_SECONDS_COLOR, colon: RST_COLON_COLOR};
      owed_q.delete();
    end else begin
      // palette writes
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_HOURS_COLOR:   colors.hours   = cfg_wdata;
          REG_MINUTES_COLOR: colors.minutes = cfg_wdata;
          REG_SECONDS_COLOR: colors.seconds = cfg_wdata;
          REG_COLON_COLOR:   colors.colon   = cfg_wdata;
        endcase
      end

      // input transaction: update the time or shade a pixel
      if (in_tvalid && in_tready) begin
        want.written = 1'b0;
        want.color   = 8'd0;
        case (mode_t'(in_tuser))
          MODE_TICK:  advance_second();
          MODE_QUERY: shade_pixel(int'(in_tdata[9:0]), int'(in_tdata[19:10]),
                                  want.written, want.color);
          MODE_SET: begin
            set_h = in_tdata[23:20];
            set_m = in_tdata[29:24];
            set_s = in_tdata[35:30];
            time_now.hours   = (set_h > MAX_HOURS)   ? MAX_HOURS   : set_h;
            time_now.minutes = (set_m > MAX_MIN_SEC) ? MAX_MIN_SEC : set_m;
            time_now.seconds = (set_s > MAX_MIN_SEC) ? MAX_MIN_SEC : set_s;
          end
          default: ;
        endcase
        want.now = time_now;
        owed_q.push_back(want);
      end

      // result transaction against the oldest owed result
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with nothing owed", 1, 0);
        end else begin
          want  = owed_q.pop_front();
          got_h = out_tdata[12:9];
          got_m = out_tdata[18:13];
          got_s = out_tdata[24:19];
          if (out_tdata[0] !== want.written)
            report_mismatch("pixel_written", int'(out_tdata[0]), int'(want.written));
          if (out_tdata[8:1] !== want.color)
            report_mismatch("pixel_color", int'(out_tdata[8:1]), int'(want.color));
          if (got_h !== want.now.hours)
            report_mismatch("hours_now", int'(got_h), int'(want.now.hours));
          if (got_m !== want.now.minutes)
            report_mismatch("minutes_now", int'(got_m), int'(want.now.minutes));
          if (got_s !== want.now.seconds)
            report_mismatch("seconds_now", int'(got_s), int'(want.now.seconds));
        end
      end
    end
    owed = owed_q.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdpr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // pixel_x, pixel_y, set_hours, set_minutes, set_seconds
  logic [1:0]  in_tuser   = MODE_TICK;   // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // pixel_written, pixel_color, hours_now, minutes_now,
                                  // seconds_now
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = REG_HOURS_COLOR;
  logic [7:0]  cfg_wdata  = '0;

  int mismatches;
  int results_owed;
  int cycle_count   = 0;
  int send_idle     = 0;
  int recv_stall    = 0;
  int hold_requests = 0;

  clock_digit_pixel_renderer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  clock_render_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .results_owed   (results_owed)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic offer_item(input mode_t mode, input logic [9:0] px, input logic [9:0] py,
                            input logic [3:0] sh, input logic [5:0] sm, input logic [5:0] ss);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, ss, sm, sh, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic query(input int px, input int py);
    offer_item(MODE_QUERY, 10'(px), 10'(py), 4'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic set_time(input int sh, input int sm, input int ss);
    offer_item(MODE_SET, 10'($urandom), 10'($urandom), 4'(sh), 6'(sm), 6'(ss));
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_palette(input logic [7:0] h, input logic [7:0] m,
                               input logic [7:0] s, input logic [7:0] c);
    reg_idx_t   regs [4];
    logic [7:0] vals [4];
    regs = '{REG_HOURS_COLOR, REG_MINUTES_COLOR, REG_SECONDS_COLOR, REG_COLON_COLOR};
    vals = '{h, m, s, c};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly queries around the glyph row, with ticks and sets to move the time
  task automatic random_item();
    int pick;
    int flavour;
    pick = $urandom_range(99);
    if (pick < 58) begin
      if ($urandom_range(9) == 0)
        query($urandom_range(1023), $urandom_range(1023));
      else
        query($urandom_range(9) * 64 + $urandom_range(63), $urandom_range(150, 330));
    end else if (pick < 80) begin
      offer_item(MODE_TICK, 10'($urandom), 10'($urandom), 4'($urandom), 6'($urandom),
                 6'($urandom));
    end else if (pick < 95) begin
      flavour = $urandom_range(2);
      if (flavour == 0)
        set_time($urandom_range(15), $urandom_range(63), $urandom_range(63));
      else if (flavour == 1)
        set_time($urandom_range(10, 12), $urandom_range(57, 59), $urandom_range(55, 59));
      else
        set_time($urandom_range(12), $urandom_range(59), $urandom_range(59));
    end else begin
      offer_item(MODE_IDLE, 10'($urandom), 10'($urandom), 4'($urandom), 6'($urandom),
                 6'($urandom));
    end
  endtask

  task automatic random_phase(input int items, input int idle_pct, input int stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (items) random_item();
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset time 05:12:00 and reset palette
    query(64 + 30, 240);            // hour tens zero, hollow centre
    query(65, 161);                 // first pixel inside a box
    query(64, 200);                 // box left edge, not drawn
    query(64 + 54, 200);            // gap between boxes
    query(64 + 53, 319);            // last pixel inside a box
    query(0, 0);
    query(1023, 1023);
    query(639, 639);
    query(640, 200);                // beyond the screen side
    query(192 + 20, 170);           // colon background
    query(192 + 20, 200);           // colon upper dot
    query(384 + 5, 260);            // colon gap between dots
    query(384 + 5, 270);            // colon lower dot
    set_time(15, 63, 63);           // clamped to 12:59:59
    offer_item(MODE_TICK, '0, '0, '0, '0, '0);   // hours wrap to zero
    query(512 + 30, 240);
    set_time(1, 11, 11);
    query(64 + 17, 240);            // hour tens zero, inside its left stroke
    query(64 + 16, 240);
    query(256 + 37, 100 + 160);
    offer_item(MODE_IDLE, '1, '1, '1, '1, '1);   // unused mode
    set_time(0, 59, 58);
    offer_item(MODE_TICK, '1, '1, '1, '1, '1);
    offer_item(MODE_TICK, '0, '0, '0, '0, '0);   // minute carry
    query(320 + 30, 250);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_palette(8'd0, 8'd0, 8'd0, 8'd0);
    hold_requests++;
    random_phase(60, 0, 0);

    write_palette(8'd255, 8'd255, 8'd255, 8'd255);
    random_phase(255, 47, 0);

    write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(255, 0, 47);

    write_palette(8'd1, 8'd128, 8'd254, 8'd127);
    random_phase(255, 25, 25);

    write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(255, 0, 0);

    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
